// ===== design/oriented_rect_overlap_test_macros.svh =====
// ----------------------------------------------------------------------------
// oriented_rect_overlap_test_macros
// Assertion helpers for the oriented rectangle overlap test. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ORIENTED_RECT_OVERLAP_TEST_MACROS_SVH
`define ORIENTED_RECT_OVERLAP_TEST_MACROS_SVH
`ifndef SYNTHESIS
// property checked outside reset
`define RO_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// property checked on every edge, reset included
`define RO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RO_ASSERT(lbl, clk, rstn, prop, msg)
`define RO_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/rect_ovl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_ovl_pkg
// Shared widths and codes of the oriented rectangle overlap test.
// ----------------------------------------------------------------------------
package rect_ovl_pkg;

  // default field widths
  localparam int COORD_WIDTH_DEF    = 24;
  localparam int TRIG_FRAC_BITS_DEF = 14;

  // separating axis codes, in test order
  typedef enum logic [2:0] {
    AXIS_NONE = 3'd0,
    AXIS_A0   = 3'd1,
    AXIS_A1   = 3'd2,
    AXIS_B0   = 3'd3,
    AXIS_B1   = 3'd4
  } axis_t;

endpackage

// ===== design/oriented_rect_overlap_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_rect_overlap_test
// Separating axis test on two oriented rectangles, plus the overlap of their
// axis aligned bounding boxes.
// ----------------------------------------------------------------------------
// Usage:
//   An item (two boxes: centre, half sizes, cos and sin) is taken at a rising
//   edge where start is high and busy is low. busy is always low: the block
//   takes one item in every cycle.
//   The result shows on the out_ ports for exactly one cycle, marked by
//   out_valid. Items come out in the order they went in, one per cycle at
//   most. The pipeline has six register stages: trig products, axis dot
//   products, radius multipliers, radius sums and edge min/max, axis
//   compares and overlap subtract, then encoding and rounding.
//   The radius multipliers (dot product magnitude by half size) set the
//   longest path.
//   The receiver cannot stall: each result is taken in the cycle it shows.
//   A synchronous reset (rst_n low) drops every item in flight; no result
//   strobe follows until new items are taken.
// ----------------------------------------------------------------------------
`include "oriented_rect_overlap_test_macros.svh"

module oriented_rect_overlap_test #(
  parameter int COORD_WIDTH    = rect_ovl_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = rect_ovl_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       in_a_center_x,
  input  logic signed [COORD_WIDTH-1:0]       in_a_center_y,
  input  logic        [COORD_WIDTH-3:0]       in_a_half_w,
  input  logic        [COORD_WIDTH-3:0]       in_a_half_h,
  input  logic signed [TRIG_FRAC_BITS+1:0]    in_a_cos,
  input  logic signed [TRIG_FRAC_BITS+1:0]    in_a_sin,
  input  logic signed [COORD_WIDTH-1:0]       in_b_center_x,
  input  logic signed [COORD_WIDTH-1:0]       in_b_center_y,
  input  logic        [COORD_WIDTH-3:0]       in_b_half_w,
  input  logic        [COORD_WIDTH-3:0]       in_b_half_h,
  input  logic signed [TRIG_FRAC_BITS+1:0]    in_b_cos,
  input  logic signed [TRIG_FRAC_BITS+1:0]    in_b_sin,
  output logic                                out_valid,
  output logic                                out_obb_hit,
  output rect_ovl_pkg::axis_t                 out_first_separating_axis,
  output logic                                out_aabb_hit,
  output logic signed [COORD_WIDTH+1:0]       out_overlap_x,
  output logic signed [COORD_WIDTH+1:0]       out_overlap_y
);
  import rect_ovl_pkg::*;

  // derived widths
  localparam int HW   = COORD_WIDTH - 2;           // half size
  localparam int TW   = TRIG_FRAC_BITS + 2;        // trig value
  localparam int OW   = COORD_WIDTH + 2;           // overlap output
  localparam int DW   = COORD_WIDTH + 1;           // centre difference
  localparam int TP   = 2 * TW;                    // trig by trig product
  localparam int TS   = TP + 1;                    // sum of two trig products
  localparam int NW   = TP;                        // dot product magnitude
  localparam int RP   = NW + HW;                   // radius term
  localparam int RS   = RP + 2;                    // radius sum of three terms
  localparam int PP   = DW + TW;                   // projection term
  localparam int PS   = PP + 1;                    // projection sum
  localparam int PSH  = PS + TRIG_FRAC_BITS;       // projection scaled to radius format
  localparam int CMPW = (RS > PSH) ? RS : PSH;     // axis compare width
  localparam int EP   = TW + HW;                   // extent term
  localparam int ES   = EP + 1;                    // extent
  localparam int EGW  = COORD_WIDTH + TRIG_FRAC_BITS + 3; // box edge
  localparam int OVW  = EGW + 1;                   // exact overlap
  localparam int RNW  = OVW - TRIG_FRAC_BITS;      // rounded overlap
  localparam int LAT  = 6;                         // register stages

  localparam logic signed [OVW-1:0] RND_BIAS = OVW'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [RNW-1:0] OV_MAX   = {{(RNW - OW + 1){1'b0}}, {(OW - 1){1'b1}}};
  localparam logic signed [RNW-1:0] OV_MIN   = ~OV_MAX;

  // round half up to Q.8 and saturate to the output range
  function automatic logic signed [OW-1:0] round_sat(input logic signed [OVW-1:0] v);
    logic signed [OVW-1:0] biased;
    logic signed [RNW-1:0] rnd;
    logic signed [RNW-1:0] clip;
    biased = v + RND_BIAS;
    rnd    = $signed(biased[OVW-1:TRIG_FRAC_BITS]);
    if (rnd > OV_MAX) begin
      clip = OV_MAX;
    end else if (rnd < OV_MIN) begin
      clip = OV_MIN;
    end else begin
      clip = rnd;
    end
    return clip[OW-1:0];
  endfunction

  // handshake and valid pipeline
  logic             in_accept;
  logic [LAT-1:0]   vld_r;

  assign busy      = 1'b0;
  assign in_accept = start & ~busy;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], in_accept};
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic [TW-1:0] a_cos_mag, a_sin_mag, b_cos_mag, b_sin_mag;

  // trig magnitudes, the most negative code reads as its unsigned magnitude
  always_comb begin
    a_cos_mag = in_a_cos[TW-1] ? -in_a_cos : in_a_cos;
    a_sin_mag = in_a_sin[TW-1] ? -in_a_sin : in_a_sin;
    b_cos_mag = in_b_cos[TW-1] ? -in_b_cos : in_b_cos;
    b_sin_mag = in_b_sin[TW-1] ? -in_b_sin : in_b_sin;
  end

  logic signed [DW-1:0] s1_dx_r, s1_dy_r;
  logic signed [TP-1:0] s1_acbc_r, s1_asbs_r, s1_asbc_r, s1_acbs_r;
  logic signed [TP-1:0] s1_acac_r, s1_asas_r, s1_bcbc_r, s1_bsbs_r;
  logic signed [TW-1:0] s1_ac_r, s1_as_r, s1_bc_r, s1_bs_r;
  logic [HW-1:0]        s1_ahw_r, s1_ahh_r, s1_bhw_r, s1_bhh_r;
  logic signed [COORD_WIDTH-1:0] s1_acx_r, s1_acy_r, s1_bcx_r, s1_bcy_r;
  logic [EP-1:0]        s1_xacw_r, s1_xash_r, s1_yasw_r, s1_yach_r;
  logic [EP-1:0]        s1_xbcw_r, s1_xbsh_r, s1_ybsw_r, s1_ybch_r;

  // centre differences, trig cross products and extent terms
  always_ff @(posedge clk) begin
    s1_dx_r   <= DW'(in_a_center_x) - DW'(in_b_center_x);
    s1_dy_r   <= DW'(in_a_center_y) - DW'(in_b_center_y);
    s1_acbc_r <= TP'(in_a_cos) * TP'(in_b_cos);
    s1_asbs_r <= TP'(in_a_sin) * TP'(in_b_sin);
    s1_asbc_r <= TP'(in_a_sin) * TP'(in_b_cos);
    s1_acbs_r <= TP'(in_a_cos) * TP'(in_b_sin);
    s1_acac_r <= TP'(in_a_cos) * TP'(in_a_cos);
    s1_asas_r <= TP'(in_a_sin) * TP'(in_a_sin);
    s1_bcbc_r <= TP'(in_b_cos) * TP'(in_b_cos);
    s1_bsbs_r <= TP'(in_b_sin) * TP'(in_b_sin);
    s1_xacw_r <= EP'(a_cos_mag) * EP'(in_a_half_w);
    s1_xash_r <= EP'(a_sin_mag) * EP'(in_a_half_h);
    s1_yasw_r <= EP'(a_sin_mag) * EP'(in_a_half_w);
    s1_yach_r <= EP'(a_cos_mag) * EP'(in_a_half_h);
    s1_xbcw_r <= EP'(b_cos_mag) * EP'(in_b_half_w);
    s1_xbsh_r <= EP'(b_sin_mag) * EP'(in_b_half_h);
    s1_ybsw_r <= EP'(b_sin_mag) * EP'(in_b_half_w);
    s1_ybch_r <= EP'(b_cos_mag) * EP'(in_b_half_h);
    s1_ac_r   <= in_a_cos;
    s1_as_r   <= in_a_sin;
    s1_bc_r   <= in_b_cos;
    s1_bs_r   <= in_b_sin;
    s1_ahw_r  <= in_a_half_w;
    s1_ahh_r  <= in_a_half_h;
    s1_bhw_r  <= in_b_half_w;
    s1_bhh_r  <= in_b_half_h;
    s1_acx_r  <= in_a_center_x;
    s1_acy_r  <= in_a_center_y;
    s1_bcx_r  <= in_b_center_x;
    s1_bcy_r  <= in_b_center_y;
  end

  // ---------------------------------------------------------------- stage 2
  // axis dot products: |A0.A0| = nA, |A0.B0| = |A1.B1| = |k|,
  // |A0.B1| = |A1.B0| = |m|, |B0.B0| = nB, own cross terms are zero
  logic signed [TS-1:0] na_sum, nb_sum, k_sum, m_sum;
  logic signed [TS-1:0] k_abs, m_abs;
  logic [NW-1:0]        s2_na_nxt, s2_nb_nxt, s2_k_nxt, s2_m_nxt;

  always_comb begin
    na_sum    = TS'(s1_acac_r) + TS'(s1_asas_r);
    nb_sum    = TS'(s1_bcbc_r) + TS'(s1_bsbs_r);
    k_sum     = TS'(s1_acbc_r) + TS'(s1_asbs_r);
    m_sum     = TS'(s1_asbc_r) - TS'(s1_acbs_r);
    k_abs     = k_sum[TS-1] ? -k_sum : k_sum;
    m_abs     = m_sum[TS-1] ? -m_sum : m_sum;
    s2_na_nxt = na_sum[NW-1:0];
    s2_nb_nxt = nb_sum[NW-1:0];
    s2_k_nxt  = k_abs[NW-1:0];
    s2_m_nxt  = m_abs[NW-1:0];
  end

  logic [NW-1:0]        s2_na_r, s2_nb_r, s2_k_r, s2_m_r;
  logic signed [PP-1:0] s2_dxac_r, s2_dyas_r, s2_dyac_r, s2_dxas_r;
  logic signed [PP-1:0] s2_dxbc_r, s2_dybs_r, s2_dybc_r, s2_dxbs_r;
  logic [ES-1:0]        s2_exa_r, s2_eya_r, s2_exb_r, s2_eyb_r;
  logic [HW-1:0]        s2_ahw_r, s2_ahh_r, s2_bhw_r, s2_bhh_r;
  logic signed [COORD_WIDTH-1:0] s2_acx_r, s2_acy_r, s2_bcx_r, s2_bcy_r;

  // projection terms and bounding box extents
  always_ff @(posedge clk) begin
    s2_na_r   <= s2_na_nxt;
    s2_nb_r   <= s2_nb_nxt;
    s2_k_r    <= s2_k_nxt;
    s2_m_r    <= s2_m_nxt;
    s2_dxac_r <= PP'(s1_dx_r) * PP'(s1_ac_r);
    s2_dyas_r <= PP'(s1_dy_r) * PP'(s1_as_r);
    s2_dyac_r <= PP'(s1_dy_r) * PP'(s1_ac_r);
    s2_dxas_r <= PP'(s1_dx_r) * PP'(s1_as_r);
    s2_dxbc_r <= PP'(s1_dx_r) * PP'(s1_bc_r);
    s2_dybs_r <= PP'(s1_dy_r) * PP'(s1_bs_r);
    s2_dybc_r <= PP'(s1_dy_r) * PP'(s1_bc_r);
    s2_dxbs_r <= PP'(s1_dx_r) * PP'(s1_bs_r);
    s2_exa_r  <= ES'(s1_xacw_r) + ES'(s1_xash_r);
    s2_eya_r  <= ES'(s1_yasw_r) + ES'(s1_yach_r);
    s2_exb_r  <= ES'(s1_xbcw_r) + ES'(s1_xbsh_r);
    s2_eyb_r  <= ES'(s1_ybsw_r) + ES'(s1_ybch_r);
    s2_ahw_r  <= s1_ahw_r;
    s2_ahh_r  <= s1_ahh_r;
    s2_bhw_r  <= s1_bhw_r;
    s2_bhh_r  <= s1_bhh_r;
    s2_acx_r  <= s1_acx_r;
    s2_acy_r  <= s1_acy_r;
    s2_bcx_r  <= s1_bcx_r;
    s2_bcy_r  <= s1_bcy_r;
  end

  // ---------------------------------------------------------------- stage 3
  logic signed [PS-1:0]  p_sum [4];
  logic [PS-1:0]         s3_pmag_nxt [4];
  logic signed [EGW-1:0] acx_s, acy_s, bcx_s, bcy_s;
  logic signed [EGW-1:0] exa_s, eya_s, exb_s, eyb_s;

  // projected centre distance on each axis, and centres moved to Q.(8+T)
  always_comb begin
    p_sum[0] = PS'(s2_dxac_r) + PS'(s2_dyas_r);
    p_sum[1] = PS'(s2_dyac_r) - PS'(s2_dxas_r);
    p_sum[2] = PS'(s2_dxbc_r) + PS'(s2_dybs_r);
    p_sum[3] = PS'(s2_dybc_r) - PS'(s2_dxbs_r);
    for (int i = 0; i < 4; i++) begin
      s3_pmag_nxt[i] = p_sum[i][PS-1] ? -p_sum[i] : p_sum[i];
    end
    acx_s = EGW'($signed({s2_acx_r, {TRIG_FRAC_BITS{1'b0}}}));
    acy_s = EGW'($signed({s2_acy_r, {TRIG_FRAC_BITS{1'b0}}}));
    bcx_s = EGW'($signed({s2_bcx_r, {TRIG_FRAC_BITS{1'b0}}}));
    bcy_s = EGW'($signed({s2_bcy_r, {TRIG_FRAC_BITS{1'b0}}}));
    exa_s = EGW'(s2_exa_r);
    eya_s = EGW'(s2_eya_r);
    exb_s = EGW'(s2_exb_r);
    eyb_s = EGW'(s2_eyb_r);
  end

  logic [RP-1:0]         s3_na_aw_r, s3_na_ah_r, s3_nb_bw_r, s3_nb_bh_r;
  logic [RP-1:0]         s3_k_aw_r, s3_k_ah_r, s3_m_aw_r, s3_m_ah_r;
  logic [RP-1:0]         s3_k_bw_r, s3_k_bh_r, s3_m_bw_r, s3_m_bh_r;
  logic [PS-1:0]         s3_pmag_r [4];
  logic signed [EGW-1:0] s3_axl_r, s3_axh_r, s3_ayl_r, s3_ayh_r;
  logic signed [EGW-1:0] s3_bxl_r, s3_bxh_r, s3_byl_r, s3_byh_r;

  // radius terms and bounding box edges
  always_ff @(posedge clk) begin
    s3_na_aw_r <= RP'(s2_na_r) * RP'(s2_ahw_r);
    s3_na_ah_r <= RP'(s2_na_r) * RP'(s2_ahh_r);
    s3_nb_bw_r <= RP'(s2_nb_r) * RP'(s2_bhw_r);
    s3_nb_bh_r <= RP'(s2_nb_r) * RP'(s2_bhh_r);
    s3_k_aw_r  <= RP'(s2_k_r) * RP'(s2_ahw_r);
    s3_k_ah_r  <= RP'(s2_k_r) * RP'(s2_ahh_r);
    s3_m_aw_r  <= RP'(s2_m_r) * RP'(s2_ahw_r);
    s3_m_ah_r  <= RP'(s2_m_r) * RP'(s2_ahh_r);
    s3_k_bw_r  <= RP'(s2_k_r) * RP'(s2_bhw_r);
    s3_k_bh_r  <= RP'(s2_k_r) * RP'(s2_bhh_r);
    s3_m_bw_r  <= RP'(s2_m_r) * RP'(s2_bhw_r);
    s3_m_bh_r  <= RP'(s2_m_r) * RP'(s2_bhh_r);
    for (int i = 0; i < 4; i++) begin
      s3_pmag_r[i] <= s3_pmag_nxt[i];
    end
    s3_axl_r <= acx_s - exa_s;
    s3_axh_r <= acx_s + exa_s;
    s3_ayl_r <= acy_s - eya_s;
    s3_ayh_r <= acy_s + eya_s;
    s3_bxl_r <= bcx_s - exb_s;
    s3_bxh_r <= bcx_s + exb_s;
    s3_byl_r <= bcy_s - eyb_s;
    s3_byh_r <= bcy_s + eyb_s;
  end

  // ---------------------------------------------------------------- stage 4
  logic [RS-1:0]         s4_rad_nxt [4];
  logic signed [EGW-1:0] s4_rx_nxt, s4_lx_nxt, s4_ry_nxt, s4_ly_nxt;

  // radius sum per axis, both boxes; nearest edges of the bounding boxes
  always_comb begin
    s4_rad_nxt[0] = RS'(s3_na_aw_r) + RS'(s3_k_bw_r) + RS'(s3_m_bh_r);
    s4_rad_nxt[1] = RS'(s3_na_ah_r) + RS'(s3_m_bw_r) + RS'(s3_k_bh_r);
    s4_rad_nxt[2] = RS'(s3_k_aw_r) + RS'(s3_m_ah_r) + RS'(s3_nb_bw_r);
    s4_rad_nxt[3] = RS'(s3_m_aw_r) + RS'(s3_k_ah_r) + RS'(s3_nb_bh_r);
    s4_rx_nxt = (s3_axh_r < s3_bxh_r) ? s3_axh_r : s3_bxh_r;
    s4_lx_nxt = (s3_axl_r > s3_bxl_r) ? s3_axl_r : s3_bxl_r;
    s4_ry_nxt = (s3_ayh_r < s3_byh_r) ? s3_ayh_r : s3_byh_r;
    s4_ly_nxt = (s3_ayl_r > s3_byl_r) ? s3_ayl_r : s3_byl_r;
  end

  logic [RS-1:0]         s4_rad_r [4];
  logic [PS-1:0]         s4_pmag_r [4];
  logic signed [EGW-1:0] s4_rx_r, s4_lx_r, s4_ry_r, s4_ly_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      s4_rad_r[i]  <= s4_rad_nxt[i];
      s4_pmag_r[i] <= s3_pmag_r[i];
    end
    s4_rx_r <= s4_rx_nxt;
    s4_lx_r <= s4_lx_nxt;
    s4_ry_r <= s4_ry_nxt;
    s4_ly_r <= s4_ly_nxt;
  end

  // ---------------------------------------------------------------- stage 5
  logic [3:0] s5_sep_nxt;

  // an axis separates when the scaled distance exceeds the radius sum
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s5_sep_nxt[i] = CMPW'({s4_pmag_r[i], {TRIG_FRAC_BITS{1'b0}}}) > CMPW'(s4_rad_r[i]);
    end
  end

  logic [3:0]            s5_sep_r;
  logic signed [OVW-1:0] s5_ovx_r, s5_ovy_r;

  always_ff @(posedge clk) begin
    s5_sep_r <= s5_sep_nxt;
    s5_ovx_r <= OVW'(s4_rx_r) - OVW'(s4_lx_r);
    s5_ovy_r <= OVW'(s4_ry_r) - OVW'(s4_ly_r);
  end

  // ---------------------------------------------------------------- stage 6
  axis_t                out_axis_nxt;
  logic signed [OW-1:0] out_ovx_nxt, out_ovy_nxt;

  // first separating axis in test order, rounded overlaps
  always_comb begin
    if (s5_sep_r[0]) begin
      out_axis_nxt = AXIS_A0;
    end else if (s5_sep_r[1]) begin
      out_axis_nxt = AXIS_A1;
    end else if (s5_sep_r[2]) begin
      out_axis_nxt = AXIS_B0;
    end else if (s5_sep_r[3]) begin
      out_axis_nxt = AXIS_B1;
    end else begin
      out_axis_nxt = AXIS_NONE;
    end
    out_ovx_nxt = round_sat(s5_ovx_r);
    out_ovy_nxt = round_sat(s5_ovy_r);
  end

  logic                 out_obb_r;
  axis_t                out_axis_r;
  logic                 out_aabb_r;
  logic signed [OW-1:0] out_ovx_r, out_ovy_r;

  always_ff @(posedge clk) begin
    out_obb_r  <= ~(|s5_sep_r);
    out_axis_r <= out_axis_nxt;
    out_aabb_r <= (out_ovx_nxt > 0) && (out_ovy_nxt > 0);
    out_ovx_r  <= out_ovx_nxt;
    out_ovy_r  <= out_ovy_nxt;
  end

  assign out_obb_hit               = out_obb_r;
  assign out_first_separating_axis = out_axis_r;
  assign out_aabb_hit              = out_aabb_r;
  assign out_overlap_x             = out_ovx_r;
  assign out_overlap_y             = out_ovy_r;

  // ------------------------------------------------------------- assertions
  `RO_ASSERT(a_item_latency, clk, rst_n, in_accept |-> ##LAT out_valid, "item lost in pipeline")
  `RO_ASSERT_ALWAYS(a_quiet_after_reset, clk, $past(!rst_n) |-> !out_valid, "strobe after reset")
  `RO_ASSERT(a_hit_matches_axis, clk, rst_n, out_valid |-> (out_obb_hit == (out_first_separating_axis == AXIS_NONE)), "hit flag and axis disagree")
  `RO_ASSERT(a_aabb_positive, clk, rst_n, (out_valid && out_aabb_hit) |-> (out_overlap_x > 0 && out_overlap_y > 0), "aabb hit without overlap")

endmodule

// ===== tb/sv/rect_overlap_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_overlap_checker
// Watches the item and result channels of the oriented rectangle overlap
// test. Each accepted box pair is judged by an exact separating axis and
// bounding box calculation, and every result strobe is compared field by
// field with the oldest verdict still waiting.
// ----------------------------------------------------------------------------
module rect_overlap_checker #(
  parameter int COORD_WIDTH    = rect_ovl_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = rect_ovl_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [COORD_WIDTH-1:0]     in_a_center_x,
  input  logic signed [COORD_WIDTH-1:0]     in_a_center_y,
  input  logic        [COORD_WIDTH-3:0]     in_a_half_w,
  input  logic        [COORD_WIDTH-3:0]     in_a_half_h,
  input  logic signed [TRIG_FRAC_BITS+1:0]  in_a_cos,
  input  logic signed [TRIG_FRAC_BITS+1:0]  in_a_sin,
  input  logic signed [COORD_WIDTH-1:0]     in_b_center_x,
  input  logic signed [COORD_WIDTH-1:0]     in_b_center_y,
  input  logic        [COORD_WIDTH-3:0]     in_b_half_w,
  input  logic        [COORD_WIDTH-3:0]     in_b_half_h,
  input  logic signed [TRIG_FRAC_BITS+1:0]  in_b_cos,
  input  logic signed [TRIG_FRAC_BITS+1:0]  in_b_sin,
  input  logic                              out_valid,
  input  logic                              out_obb_hit,
  input  rect_ovl_pkg::axis_t               out_first_separating_axis,
  input  logic                              out_aabb_hit,
  input  logic signed [COORD_WIDTH+1:0]     out_overlap_x,
  input  logic signed [COORD_WIDTH+1:0]     out_overlap_y,
  output int                                mismatch_count,
  output int                                verdicts_waiting
);
  import rect_ovl_pkg::*;

  localparam int OVL_WIDTH   = COORD_WIDTH + 2;

  // one box, widened so that no product can overflow
  typedef struct {
    longint cx;
    longint cy;
    longint hw;
    longint hh;
    longint c;
    longint s;
  } rect_t;

  typedef struct {
    logic                          obb_hit;
    axis_t                         axis;
    logic                          aabb_hit;
    logic signed [OVL_WIDTH-1:0]   ovl_x;
    logic signed [OVL_WIDTH-1:0]   ovl_y;
  } verdict_t;

  verdict_t pending_verdicts[$];

  function automatic longint absval(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // projected radius of a box on axis (ux, uy), in Q.(8+2T)
  function automatic longint span_on(longint ux, longint uy, rect_t r);
    longint d0;
    longint d1;
    d0 = ux * r.c + uy * r.s;
    d1 = uy * r.c - ux * r.s;
    return absval(d0) * r.hw + absval(d1) * r.hh;
  endfunction

  // centre distance strictly beyond the radius sum separates
  function automatic bit axis_splits(longint ux, longint uy, rect_t a, rect_t b);
    longint p;
    p = (a.cx - b.cx) * ux + (a.cy - b.cy) * uy;
    return absval(p) * (longint'(1) << TRIG_FRAC_BITS) > span_on(ux, uy, a) + span_on(ux, uy, b);
  endfunction

  // Q.(8+T) to Q.8, half rounds up, then clipped to the output range
  function automatic logic signed [OVL_WIDTH-1:0] to_q8(longint v);
    longint r;
    longint top;
    r   = (v + (longint'(1) << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    top = (longint'(1) << (OVL_WIDTH - 1)) - 1;
    if (r > top) r = top;
    if (r < -top - 1) r = -top - 1;
    return r[OVL_WIDTH-1:0];
  endfunction

  function automatic verdict_t judge_pair(rect_t a, rect_t b);
    verdict_t v;
    longint   one;
    longint   exa, eya, exb, eyb;
    longint   ax, ay, bx, by;
    longint   lo, hi;
    one = longint'(1) << TRIG_FRAC_BITS;

    // axes in fixed order, first one that separates wins
    if (axis_splits(a.c, a.s, a, b))       v.axis = AXIS_A0;
    else if (axis_splits(-a.s, a.c, a, b)) v.axis = AXIS_A1;
    else if (axis_splits(b.c, b.s, a, b))  v.axis = AXIS_B0;
    else if (axis_splits(-b.s, b.c, a, b)) v.axis = AXIS_B1;
    else                                   v.axis = AXIS_NONE;
    v.obb_hit = (v.axis == AXIS_NONE);

    // bounding box extents and overlap widths
    exa = absval(a.c) * a.hw + absval(a.s) * a.hh;
    eya = absval(a.s) * a.hw + absval(a.c) * a.hh;
    exb = absval(b.c) * b.hw + absval(b.s) * b.hh;
    eyb = absval(b.s) * b.hw + absval(b.c) * b.hh;
    ax  = a.cx * one;
    ay  = a.cy * one;
    bx  = b.cx * one;
    by  = b.cy * one;
    hi  = (ax + exa < bx + exb) ? ax + exa : bx + exb;
    lo  = (ax - exa > bx - exb) ? ax - exa : bx - exb;
    v.ovl_x = to_q8(hi - lo);
    hi  = (ay + eya < by + eyb) ? ay + eya : by + eyb;
    lo  = (ay - eya > by - eyb) ? ay - eya : by - eyb;
    v.ovl_y = to_q8(hi - lo);
    v.aabb_hit = (v.ovl_x > 0) && (v.ovl_y > 0);
    return v;
  endfunction

  function automatic rect_t rect_of(
    logic signed [COORD_WIDTH-1:0] cx, logic signed [COORD_WIDTH-1:0] cy,
    logic [COORD_WIDTH-3:0] hw, logic [COORD_WIDTH-3:0] hh,
    logic signed [TRIG_FRAC_BITS+1:0] c, logic signed [TRIG_FRAC_BITS+1:0] s);
    rect_t r;
    r.cx = cx;
    r.cy = cy;
    r.hw = hw;
    r.hh = hh;
    r.c  = c;
    r.s  = s;
    return r;
  endfunction

  task automatic check_field(string field, logic signed [63:0] want,
                             logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // results first, then the item taken at this edge
  always @(posedge clk) begin : watch_channels
    verdict_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_verdicts.size() == 0) begin
          $display("%0t: result with no item waiting, expected none, actual axis %0d",
                   $time, out_first_separating_axis);
          mismatch_count++;
        end else begin
          want = pending_verdicts.pop_front();
          check_field("obb_hit", 64'(want.obb_hit), 64'(out_obb_hit));
          check_field("first_separating_axis", 64'(want.axis),
                      64'(out_first_separating_axis));
          check_field("aabb_hit", 64'(want.aabb_hit), 64'(out_aabb_hit));
          check_field("overlap_x", 64'(want.ovl_x), 64'(out_overlap_x));
          check_field("overlap_y", 64'(want.ovl_y), 64'(out_overlap_y));
        end
      end
      if (start && !busy)
        pending_verdicts.push_back(judge_pair(
          rect_of(in_a_center_x, in_a_center_y, in_a_half_w, in_a_half_h, in_a_cos, in_a_sin),
          rect_of(in_b_center_x, in_b_center_y, in_b_half_w, in_b_half_h, in_b_cos, in_b_sin)));
      verdicts_waiting = pending_verdicts.size();
    end
  end

endmodule

// ===== tb/sv/tb_oriented_rect_overlap_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_oriented_rect_overlap_test
// Streams box pairs into the oriented rectangle overlap test: a directed set
// of touching, separated, saturating and degenerate pairs, then random pairs
// built mostly near each other so every axis gets to separate. The checker
// beside the block judges each result; this module drives and gives verdict.
// ----------------------------------------------------------------------------
module tb_oriented_rect_overlap_test;
  import rect_ovl_pkg::*;

  localparam int CW            = COORD_WIDTH_DEF;
  localparam int TFB           = TRIG_FRAC_BITS_DEF;
  localparam int HWB           = CW - 2;
  localparam int TWB           = TFB + 2;
  localparam int Q1            = 1 << TFB;
  localparam int C45           = 11585;
  localparam int MAXC          = (1 << (CW - 1)) - 1;
  localparam int MINC          = -(1 << (CW - 1));
  localparam int MAXH          = (1 << (CW - 2)) - 1;
  localparam int RANDOM_PAIRS  = 1300;
  localparam int SETTLE_CYCLES = 12;
  localparam int QUIET_LIMIT   = 1000;

  typedef struct {
    logic signed [CW-1:0]   cx;
    logic signed [CW-1:0]   cy;
    logic        [CW-3:0]   hw;
    logic        [CW-3:0]   hh;
    logic signed [TFB+1:0]  c;
    logic signed [TFB+1:0]  s;
  } rect_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic signed [CW-1:0]  in_a_center_x, in_a_center_y, in_b_center_x, in_b_center_y;
  logic        [CW-3:0]  in_a_half_w, in_a_half_h, in_b_half_w, in_b_half_h;
  logic signed [TFB+1:0] in_a_cos, in_a_sin, in_b_cos, in_b_sin;
  logic                  out_valid;
  logic                  out_obb_hit;
  axis_t                 out_first_separating_axis;
  logic                  out_aabb_hit;
  logic signed [CW+1:0]  out_overlap_x, out_overlap_y;
  int                    mismatches;
  int                    waiting;
  int                    quiet_cycles = 0;

  oriented_rect_overlap_test #(
    .COORD_WIDTH    (CW),
    .TRIG_FRAC_BITS (TFB)
  ) dut (.*);

  rect_overlap_checker #(
    .COORD_WIDTH    (CW),
    .TRIG_FRAC_BITS (TFB)
  ) u_checker (
    .*,
    .mismatch_count   (mismatches),
    .verdicts_waiting (waiting)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on cycles with no item and no result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic rect_t mk_rect(int cx, int cy, int hw, int hh, int c, int s);
    rect_t r;
    r.cx = CW'(cx);
    r.cy = CW'(cy);
    r.hw = HWB'(hw);
    r.hh = HWB'(hh);
    r.c  = TWB'(c);
    r.s  = TWB'(s);
    return r;
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(int v);
    if (v > MAXC) return CW'(MAXC);
    if (v < MINC) return CW'(MINC);
    return CW'(v);
  endfunction

  // mostly unit vectors, some quarter turns, some raw bit patterns
  function automatic void random_angle(output logic signed [TFB+1:0] c,
                                       output logic signed [TFB+1:0] s);
    int unsigned pick;
    int unsigned k;
    real         th;
    pick = $urandom_range(99);
    if (pick < 70) begin
      th = $urandom_range(3599) * 3.14159265358979 / 1800.0;
      c  = TWB'(int'($cos(th) * Q1));
      s  = TWB'(int'($sin(th) * Q1));
    end else if (pick < 85) begin
      k = $urandom_range(3);
      c = TWB'((k == 0) ? Q1 : (k == 2) ? -Q1 : 0);
      s = TWB'((k == 1) ? Q1 : (k == 3) ? -Q1 : 0);
    end else begin
      c = TWB'($urandom);
      s = TWB'($urandom);
    end
  endfunction

  // pairs mostly close enough to one another that any axis may separate them, some fully random
  function automatic void random_pair(output rect_t a, output rect_t b);
    int unsigned kind;
    int          reach;
    int          spread;
    kind = $urandom_range(99);
    if (kind < 12) begin
      a.cx = CW'($urandom); a.cy = CW'($urandom); a.hw = HWB'($urandom); a.hh = HWB'($urandom);
      a.c  = TWB'($urandom); a.s  = TWB'($urandom);
      b.cx = CW'($urandom); b.cy = CW'($urandom); b.hw = HWB'($urandom); b.hh = HWB'($urandom);
      b.c  = TWB'($urandom); b.s  = TWB'($urandom);
    end else begin
      reach  = 1 << $urandom_range(2, CW - 2);
      spread = reach * int'($urandom_range(1, 3));
      a.cx = CW'(int'($urandom_range(1 << (CW - 1))) - (1 << (CW - 2)));
      a.cy = CW'(int'($urandom_range(1 << (CW - 1))) - (1 << (CW - 2)));
      a.hw = HWB'($urandom_range(reach - 1));
      a.hh = HWB'($urandom_range(reach - 1));
      b.hw = HWB'($urandom_range(reach - 1));
      b.hh = HWB'($urandom_range(reach - 1));
      b.cx = clamp_coord(int'(a.cx) + int'($urandom_range(2 * spread)) - spread);
      b.cy = clamp_coord(int'(a.cy) + int'($urandom_range(2 * spread)) - spread);
      random_angle(a.c, a.s);
      random_angle(b.c, b.s);
    end
  endfunction

  task automatic send_pair(input rect_t a, input rect_t b, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_a_center_x <= a.cx;
    in_a_center_y <= a.cy;
    in_a_half_w   <= a.hw;
    in_a_half_h   <= a.hh;
    in_a_cos      <= a.c;
    in_a_sin      <= a.s;
    in_b_center_x <= b.cx;
    in_b_center_y <= b.cy;
    in_b_half_w   <= b.hw;
    in_b_half_h   <= b.hh;
    in_b_cos      <= b.c;
    in_b_sin      <= b.s;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every verdict has been matched
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase_idle[4];
    rect_t       ra;
    rect_t       rb;
    phase_idle = '{0, 49, 0, 29};
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_a_center_x <= '0; in_a_center_y <= '0; in_a_half_w <= '0; in_a_half_h <= '0;
    in_a_cos      <= '0; in_a_sin      <= '0;
    in_b_center_x <= '0; in_b_center_y <= '0; in_b_half_w <= '0; in_b_half_h <= '0;
    in_b_cos      <= '0; in_b_sin      <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // degenerate boxes: zero size, zero trig, coincident points
    send_pair(mk_rect(0, 0, 0, 0, 0, 0), mk_rect(0, 0, 0, 0, 0, 0), 0);
    send_pair(mk_rect(1000, -1000, 0, 0, Q1, 0), mk_rect(1000, -1000, 0, 0, Q1, 0), 0);
    send_pair(mk_rect(0, 0, 500, 500, 0, 0), mk_rect(100000, 0, 10, 10, Q1, 0), 0);
    // field extremes, including trig beyond unit length (saturates overlap)
    send_pair(mk_rect(MAXC, MAXC, MAXH, MAXH, Q1, 0),
              mk_rect(MINC, MINC, MAXH, MAXH, -Q1, 0), 0);
    send_pair(mk_rect(MINC, MAXC, MAXH, 0, 0, Q1),
              mk_rect(MAXC, MINC, 0, MAXH, 0, -Q1), 0);
    send_pair(mk_rect(0, 0, MAXH, MAXH, 32767, -32768),
              mk_rect(0, 0, MAXH, MAXH, -32768, 32767), 0);
    send_pair(mk_rect(MINC, MINC, 1, 1, -Q1, 0), mk_rect(MINC + 1, MINC, 1, 1, 0, -Q1), 0);
    send_pair(mk_rect(0, 0, MAXH, MAXH, Q1, 0), mk_rect(5, 5, 3, 3, C45, C45), 0);
    // touching edges do not separate, zero width is no bounding box hit
    send_pair(mk_rect(0, 0, 256, 256, Q1, 0), mk_rect(512, 0, 256, 256, Q1, 0), 0);
    send_pair(mk_rect(0, 0, 256, 256, Q1, 0), mk_rect(0, 512, 256, 256, Q1, 0), 0);
    send_pair(mk_rect(0, 0, 256, 256, Q1, 0), mk_rect(513, 0, 256, 256, Q1, 0), 0);
    // each axis as the first separating one
    send_pair(mk_rect(0, 0, 256, 256, Q1, 0), mk_rect(600, 0, 256, 256, Q1, 0), 0);
    send_pair(mk_rect(0, 0, 256, 256, Q1, 0), mk_rect(0, 600, 256, 256, Q1, 0), 0);
    send_pair(mk_rect(0, 0, 25600, 25600, C45, C45),
              mk_rect(48000, 0, 10000, 10000, Q1, 0), 0);
    send_pair(mk_rect(0, 0, 25600, 25600, C45, C45),
              mk_rect(0, 48000, 10000, 10000, Q1, 0), 0);
    // rotated overlaps and rounding of the bounding box widths
    send_pair(mk_rect(100, 200, 3000, 1500, C45, -C45),
              mk_rect(-500, 700, 2000, 4000, -Q1, 0), 0);
    send_pair(mk_rect(0, 0, 1, 1, C45, C45), mk_rect(3, 0, 1, 1, C45, C45), 0);
    send_pair(mk_rect(-3000, 2000, 700, 900, -C45, -C45),
              mk_rect(-2500, 2600, 400, 100, -Q1, 0), 0);
    drain();

    // random pairs in phases of different sender idling
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < RANDOM_PAIRS / 4; n++) begin
        random_pair(ra, rb);
        send_pair(ra, rb, phase_idle[ph]);
        if ($urandom_range(199) == 0) drain();
      end
      drain();
    end

    // wait out the pipeline for stray results
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && waiting == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
